### design/i2c_rtc_register_model_defines.svh
// Assertion macros shared by the RTC register model RTL.
`ifndef I2C_RTC_REGISTER_MODEL_DEFINES_SVH
`define I2C_RTC_REGISTER_MODEL_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define I2CRTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another in the next cycle.
`define I2CRTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/i2crtc_pkg.sv
// Types and constants of the I2C RTC register model.
package i2crtc_pkg;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2,
    OpStop  = 2'd3
  } op_t;

  localparam int unsigned RegisterCount = 19;
  localparam int unsigned PtrW          = 5;
  localparam int unsigned AlarmCount    = 7;

  localparam logic [PtrW-1:0] RegSec     = 5'd0;
  localparam logic [PtrW-1:0] RegMin     = 5'd1;
  localparam logic [PtrW-1:0] RegHour    = 5'd2;
  localparam logic [PtrW-1:0] RegWday    = 5'd3;
  localparam logic [PtrW-1:0] RegDate    = 5'd4;
  localparam logic [PtrW-1:0] RegMonth   = 5'd5;
  localparam logic [PtrW-1:0] RegYear    = 5'd6;
  localparam logic [PtrW-1:0] RegA1Sec   = 5'd7;
  localparam logic [PtrW-1:0] RegA2Day   = 5'd13;
  localparam logic [PtrW-1:0] RegControl = 5'd14;
  localparam logic [PtrW-1:0] RegStatus  = 5'd15;
  localparam logic [PtrW-1:0] RegAging   = 5'd16;
  localparam logic [PtrW-1:0] RegTempHi  = 5'd17;
  localparam logic [PtrW-1:0] RegTempLo  = 5'd18;
  localparam logic [PtrW-1:0] RegLast    = 5'(RegisterCount - 1);

  localparam logic [4:0] ControlReset = 5'h1C;
  localparam logic [7:0] StatusReset  = 8'h88;
  localparam logic [7:0] TempHiValue  = 8'h19;
  localparam logic [7:0] TempLoValue  = 8'h40;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [2:0] wday;
    logic [4:0] mday;
    logic [3:0] month;
    logic [7:0] year;
  } time_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] data_byte;
    time_t      now;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       alarm1_flag;
    logic       alarm2_flag;
  } out_item_t;

endpackage

### design/i2crtc_if.sv
// Valid/ready channels for bus events in and register results out.
interface i2crtc_in_if;
  logic               valid;
  logic               ready;
  i2crtc_pkg::op_t    operation;
  logic [7:0]         data_byte;
  logic [5:0]         now_second;
  logic [5:0]         now_minute;
  logic [4:0]         now_hour;
  logic [2:0]         now_weekday;
  logic [4:0]         now_monthday;
  logic [3:0]         now_month;
  logic [7:0]         now_year;

  modport source (
    output valid, operation, data_byte, now_second, now_minute, now_hour,
           now_weekday, now_monthday, now_month, now_year,
    input  ready
  );
  modport sink (
    input  valid, operation, data_byte, now_second, now_minute, now_hour,
           now_weekday, now_monthday, now_month, now_year,
    output ready
  );
endinterface

interface i2crtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       alarm1_flag;
  logic       alarm2_flag;

  modport source (
    output valid, read_data, alarm1_flag, alarm2_flag,
    input  ready
  );
  modport sink (
    input  valid, read_data, alarm1_flag, alarm2_flag,
    output ready
  );
endinterface

### design/i2c_rtc_register_model.sv
// I2C RTC register file: each input beat passes an input register and an output
// register on its way to the result beat. Throughput one beat per cycle; the two
// registers stall together only when the output is full and not taken.
// Every register update is one short pass of logic behind the input register.
// Synchronous active-low reset: pointer 0, control 0x1C, status 0x88,
// alarms, aging and snapshot cleared, both stages empty.
`include "i2c_rtc_register_model_defines.svh"

module i2c_rtc_register_model (
  input  logic                clk,
  input  logic                rst_n,
  i2crtc_in_if.sink           in_bus,
  i2crtc_out_if.source        out_bus
);

  localparam int unsigned PtrW = i2crtc_pkg::PtrW;

  // Pipeline control
  logic                   s1_v_r, s1_v_nxt;
  i2crtc_pkg::in_item_t   s1_item_r, in_item;
  logic                   out_v_r, out_v_nxt;
  i2crtc_pkg::out_item_t  out_item_r, out_item_nxt;
  logic                   advance, proc, proc_start;

  // Architectural state
  logic [PtrW-1:0]        ptr_r, ptr_nxt;
  logic                   pend_r, pend_nxt;
  logic                   twelve_r, twelve_nxt;
  logic [7:0]             alarm_r   [i2crtc_pkg::AlarmCount];
  logic [7:0]             alarm_nxt [i2crtc_pkg::AlarmCount];
  logic [4:0]             ctrl_r, ctrl_nxt;
  logic [7:0]             status_r, status_nxt;
  logic [7:0]             aging_r, aging_nxt;
  i2crtc_pkg::time_t      snap_r, snap_nxt;

  // Datapath
  logic [PtrW-1:0]        ptr_inc, ptr_load;
  logic [2:0]             alarm_idx;
  logic [7:0]             rd_val;
  logic                   a1_fire, a2_fire;

  function automatic logic [7:0] bcd8(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 15'(v) * 15'd205;  // v / 10 by reciprocal, exact below 1029
    q = p[14:11];
    r = v - 7'(q) * 7'd10;
    return {q, r[3:0]};
  endfunction

  function automatic logic [7:0] hour_code(input logic [4:0] h, input logic mode12);
    logic       pm;
    logic [4:0] h12;
    logic [7:0] b12, b24;
    pm  = (h >= 5'd12);
    h12 = pm ? h - 5'd12 : h;
    if (h12 == 5'd0) begin
      h12 = 5'd12;
    end
    b12 = bcd8(7'(h12));
    b24 = bcd8(7'(h));
    return mode12 ? {1'b0, 1'b1, pm, b12[4:0]} : {2'b00, b24[5:0]};
  endfunction

  function automatic logic day_match(input logic [7:0] a, input logic [2:0] wday,
                                     input logic [4:0] mday);
    logic [7:0] bd;
    bd = bcd8(7'(mday));
    return a[6] ? (a[5:0] == 6'(wday) + 6'd1) : (a[5:0] == bd[5:0]);
  endfunction

  // Gather the input beat
  always_comb begin
    in_item.operation = in_bus.operation;
    in_item.data_byte = in_bus.data_byte;
    in_item.now.sec   = in_bus.now_second;
    in_item.now.min   = in_bus.now_minute;
    in_item.now.hour  = in_bus.now_hour;
    in_item.now.wday  = in_bus.now_weekday;
    in_item.now.mday  = in_bus.now_monthday;
    in_item.now.month = in_bus.now_month;
    in_item.now.year  = in_bus.now_year;
  end

  assign advance      = !out_v_r || out_bus.ready;
  assign in_bus.ready = !s1_v_r || advance;
  assign proc         = s1_v_r && advance;
  assign proc_start   = proc && (s1_item_r.operation == i2crtc_pkg::OpStart);

  assign s1_v_nxt  = in_bus.ready ? in_bus.valid : s1_v_r;
  assign out_v_nxt = advance ? s1_v_r : out_v_r;

  // Pointer arithmetic: advance with wrap, and load as byte modulo register count
  logic [12:0] mod_p;
  logic [3:0]  mod_q;
  logic [7:0]  mod_r;
  always_comb begin
    ptr_inc  = (ptr_r == i2crtc_pkg::RegLast) ? '0 : ptr_r + 1'b1;
    mod_p    = 13'(s1_item_r.data_byte) * 13'd27;  // byte / 19, exact over 8 bits
    mod_q    = mod_p[12:9];
    mod_r    = s1_item_r.data_byte - 8'(mod_q) * 8'd19;
    ptr_load = mod_r[PtrW-1:0];
    alarm_idx = 3'(ptr_r - i2crtc_pkg::RegA1Sec);
  end

  // Alarm match against the new snapshot; the once-per-second and
  // once-per-minute rates compare with the snapshot being replaced
  logic [7:0] n_sec_b, n_min_b, n_hc;
  always_comb begin
    n_sec_b = bcd8(7'(s1_item_r.now.sec));
    n_min_b = bcd8(7'(s1_item_r.now.min));
    n_hc    = hour_code(s1_item_r.now.hour, twelve_r);

    if (alarm_r[0][7]) begin
      a1_fire = (s1_item_r.now.sec != snap_r.sec);
    end else if (alarm_r[1][7]) begin
      a1_fire = (alarm_r[0][6:0] == n_sec_b[6:0]);
    end else if (alarm_r[2][7]) begin
      a1_fire = (alarm_r[0][6:0] == n_sec_b[6:0]) && (alarm_r[1][6:0] == n_min_b[6:0]);
    end else begin
      a1_fire = (alarm_r[0][6:0] == n_sec_b[6:0]) && (alarm_r[1][6:0] == n_min_b[6:0]) &&
                (alarm_r[2][6:0] == n_hc[6:0]) &&
                (alarm_r[3][7] ||
                 day_match(alarm_r[3], s1_item_r.now.wday, s1_item_r.now.mday));
    end

    if (alarm_r[4][7]) begin
      a2_fire = (s1_item_r.now.min != snap_r.min);
    end else if (alarm_r[5][7]) begin
      a2_fire = (alarm_r[4][6:0] == n_min_b[6:0]);
    end else if (alarm_r[6][7]) begin
      a2_fire = (alarm_r[4][6:0] == n_min_b[6:0]) && (alarm_r[5][6:0] == n_hc[6:0]);
    end else begin
      a2_fire = (alarm_r[4][6:0] == n_min_b[6:0]) && (alarm_r[5][6:0] == n_hc[6:0]) &&
                day_match(alarm_r[6], s1_item_r.now.wday, s1_item_r.now.mday);
    end
  end

  // Register read from the current snapshot and stored registers
  logic [7:0]  r_sec_b, r_min_b, r_hc, r_date_b, r_mon_b, r_year_b;
  logic [13:0] yr_p;
  logic [1:0]  yr_c;
  logic [7:0]  yr_rem;
  always_comb begin
    r_sec_b  = bcd8(7'(snap_r.sec));
    r_min_b  = bcd8(7'(snap_r.min));
    r_hc     = hour_code(snap_r.hour, twelve_r);
    r_date_b = bcd8(7'(snap_r.mday));
    r_mon_b  = bcd8(7'(5'(snap_r.month) + 5'd1));
    yr_p     = 14'(snap_r.year) * 14'd41;  // year / 100, exact over 8 bits
    yr_c     = yr_p[13:12];
    yr_rem   = snap_r.year - 8'(yr_c) * 8'd100;
    r_year_b = bcd8(yr_rem[6:0]);

    unique case (ptr_r) inside
      i2crtc_pkg::RegSec:     rd_val = {1'b0, r_sec_b[6:0]};
      i2crtc_pkg::RegMin:     rd_val = {1'b0, r_min_b[6:0]};
      i2crtc_pkg::RegHour:    rd_val = r_hc;
      i2crtc_pkg::RegWday:    rd_val = 8'(snap_r.wday) + 8'd1;
      i2crtc_pkg::RegDate:    rd_val = {2'b00, r_date_b[5:0]};
      i2crtc_pkg::RegMonth:   rd_val = {yr_c[0], 2'b00, r_mon_b[4:0]};
      i2crtc_pkg::RegYear:    rd_val = r_year_b;
      [i2crtc_pkg::RegA1Sec:i2crtc_pkg::RegA2Day]: rd_val = alarm_r[alarm_idx];
      i2crtc_pkg::RegControl: rd_val = {3'b000, ctrl_r};
      i2crtc_pkg::RegStatus:  rd_val = status_r;
      i2crtc_pkg::RegAging:   rd_val = aging_r;
      i2crtc_pkg::RegTempHi:  rd_val = i2crtc_pkg::TempHiValue;
      i2crtc_pkg::RegTempLo:  rd_val = i2crtc_pkg::TempLoValue;
      default:                rd_val = '0;
    endcase
  end

  // Next-state logic for one processed beat
  always_comb begin
    ptr_nxt      = ptr_r;
    pend_nxt     = pend_r;
    twelve_nxt   = twelve_r;
    alarm_nxt    = alarm_r;
    ctrl_nxt     = ctrl_r;
    status_nxt   = status_r;
    aging_nxt    = aging_r;
    snap_nxt     = snap_r;
    out_item_nxt.read_data = '0;

    if (proc) begin
      unique case (s1_item_r.operation)
        i2crtc_pkg::OpStart: begin
          snap_nxt      = s1_item_r.now;
          pend_nxt      = 1'b1;
          status_nxt[0] = status_r[0] | a1_fire;
          status_nxt[1] = status_r[1] | a2_fire;
        end
        i2crtc_pkg::OpWrite: begin
          if (pend_r) begin
            ptr_nxt  = ptr_load;
            pend_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_inc;
            unique case (ptr_r) inside
              i2crtc_pkg::RegHour: twelve_nxt = s1_item_r.data_byte[6];
              [i2crtc_pkg::RegA1Sec:i2crtc_pkg::RegA2Day]:
                alarm_nxt[alarm_idx] = s1_item_r.data_byte;
              i2crtc_pkg::RegControl: ctrl_nxt = s1_item_r.data_byte[4:0];
              i2crtc_pkg::RegStatus: begin
                // keep oscillator-stop, take bit 3, clear flags written as zero
                status_nxt = {status_r[7], 3'b000, s1_item_r.data_byte[3], 1'b0,
                              status_r[1] & s1_item_r.data_byte[1],
                              status_r[0] & s1_item_r.data_byte[0]};
              end
              i2crtc_pkg::RegAging: aging_nxt = s1_item_r.data_byte;
              default: ;
            endcase
          end
        end
        i2crtc_pkg::OpRead: begin
          out_item_nxt.read_data = rd_val;
          ptr_nxt                = ptr_inc;
        end
        i2crtc_pkg::OpStop: ;
      endcase
    end

    out_item_nxt.alarm1_flag = status_nxt[0];
    out_item_nxt.alarm2_flag = status_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      ptr_r      <= '0;
      pend_r     <= 1'b0;
      twelve_r   <= 1'b0;
      ctrl_r     <= i2crtc_pkg::ControlReset;
      status_r   <= i2crtc_pkg::StatusReset;
      aging_r    <= '0;
      snap_r     <= '0;
      for (int i = 0; i < i2crtc_pkg::AlarmCount; i++) begin
        alarm_r[i] <= '0;
      end
    end else begin
      s1_v_r     <= s1_v_nxt;
      out_v_r    <= out_v_nxt;
      ptr_r      <= ptr_nxt;
      pend_r     <= pend_nxt;
      twelve_r   <= twelve_nxt;
      ctrl_r     <= ctrl_nxt;
      status_r   <= status_nxt;
      aging_r    <= aging_nxt;
      snap_r     <= snap_nxt;
      alarm_r    <= alarm_nxt;
    end
  end

  // Payload registers: load on accept / on processing
  always_ff @(posedge clk) begin
    if (in_bus.ready) begin
      s1_item_r <= in_item;
    end
    if (proc) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.read_data   = out_item_r.read_data;
  assign out_bus.alarm1_flag = out_item_r.alarm1_flag;
  assign out_bus.alarm2_flag = out_item_r.alarm2_flag;

  `I2CRTC_ASSERT(a_ptr_range, ptr_r <= i2crtc_pkg::RegLast, "register pointer out of range")
  `I2CRTC_ASSERT_NEXT(a_start_arms, proc_start, pend_r, "start did not arm pointer load")
  `I2CRTC_ASSERT(a_osf_kept, status_r[7], "oscillator-stop flag lost")
  `I2CRTC_ASSERT(a_flag_rise, $rose(status_r[0]) |-> $past(proc_start), "A1F set outside start")
  `I2CRTC_ASSERT(a_out_flags, out_v_r |-> (out_item_r.alarm1_flag == status_r[0] && out_item_r.alarm2_flag == status_r[1]), "result flags differ from status")

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the RTC register file: random bus transfers, predicted results.
module tb;

  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 300;

  class rtc_scoreboard;
    logic [4:0]            ptr;
    bit                    pending;
    bit                    twelve_hr;
    logic [7:0]            alarm_q [i2crtc_pkg::AlarmCount];
    logic [4:0]            control;
    logic [7:0]            status;
    logic [7:0]            aging;
    i2crtc_pkg::time_t     snap_t;
    logic [5:0]            prev_sec;
    logic [5:0]            prev_min;
    i2crtc_pkg::out_item_t due_responses [$];
    int                    errors;

    function new();
      ptr       = '0;
      pending   = 1'b0;
      twelve_hr = 1'b0;
      foreach (alarm_q[i]) alarm_q[i] = '0;
      control   = i2crtc_pkg::ControlReset;
      status    = i2crtc_pkg::StatusReset;
      aging     = '0;
      snap_t    = '0;
      prev_sec  = '0;
      prev_min  = '0;
      errors    = 0;
    endfunction

    function int unsigned bcd(int unsigned v);
      return (((v / 10) << 4) + v % 10) & 'h7f;
    endfunction

    function int unsigned hour_byte();
      int unsigned h;
      int unsigned h12;
      bit          pm;
      h = snap_t.hour;
      if (twelve_hr) begin
        pm  = h >= 12;
        h12 = pm ? h - 12 : h;
        if (h12 == 0) h12 = 12;
        return (bcd(h12) & 'h1f) + (pm ? 'h60 : 'h40);
      end
      return bcd(h) & 'h3f;
    endfunction

    function bit day_hit(logic [7:0] r);
      if (r[6]) return int'(r[5:0]) == int'(snap_t.wday) + 1;
      return int'(r[5:0]) == (bcd(snap_t.mday) & 'h3f);
    endfunction

    function void check_alarms();
      int unsigned sec;
      int unsigned mins;
      int unsigned hc;
      bit          s_ok;
      bit          m_ok;
      bit          h_ok;
      bit          fire;
      sec  = snap_t.sec;
      mins = snap_t.min;
      hc   = hour_byte();
      s_ok = alarm_q[0][6:0] == bcd(sec);
      m_ok = alarm_q[1][6:0] == bcd(mins);
      h_ok = alarm_q[2][6:0] == hc;
      // lowest set mask bit picks the alarm rate
      if (alarm_q[0][7])      fire = sec != prev_sec;
      else if (alarm_q[1][7]) fire = s_ok;
      else if (alarm_q[2][7]) fire = s_ok && m_ok;
      else if (alarm_q[3][7]) fire = s_ok && m_ok && h_ok;
      else                    fire = s_ok && m_ok && h_ok && day_hit(alarm_q[3]);
      if (fire) status[0] = 1'b1;

      m_ok = alarm_q[4][6:0] == bcd(mins);
      h_ok = alarm_q[5][6:0] == hc;
      if (alarm_q[4][7])      fire = mins != prev_min;
      else if (alarm_q[5][7]) fire = m_ok;
      else if (alarm_q[6][7]) fire = m_ok && h_ok;
      else                    fire = m_ok && h_ok && day_hit(alarm_q[6]);
      if (fire) status[1] = 1'b1;
    endfunction

    function void store_byte(logic [4:0] r, logic [7:0] d);
      if (r == i2crtc_pkg::RegHour) begin
        twelve_hr = d[6];
      end else if (r >= i2crtc_pkg::RegA1Sec && r <= i2crtc_pkg::RegA2Day) begin
        alarm_q[r - i2crtc_pkg::RegA1Sec] = d;
      end else if (r == i2crtc_pkg::RegControl) begin
        control = d[4:0];
      end else if (r == i2crtc_pkg::RegStatus) begin
        // keep oscillator-stop, clear alarm flags where the byte holds zero
        status = {status[7], 3'b000, d[3], 1'b0, d[1] & status[1], d[0] & status[0]};
      end else if (r == i2crtc_pkg::RegAging) begin
        aging = d;
      end
    endfunction

    function logic [7:0] fetch_byte(logic [4:0] r);
      int unsigned yr;
      yr = snap_t.year;
      case (r)
        i2crtc_pkg::RegSec:     return 8'(bcd(snap_t.sec));
        i2crtc_pkg::RegMin:     return 8'(bcd(snap_t.min));
        i2crtc_pkg::RegHour:    return 8'(hour_byte());
        i2crtc_pkg::RegWday:    return 8'(int'(snap_t.wday) + 1);
        i2crtc_pkg::RegDate:    return 8'(bcd(snap_t.mday) & 'h3f);
        i2crtc_pkg::RegMonth:
          return 8'((((yr / 100) & 1) << 7) + (bcd(int'(snap_t.month) + 1) & 'h1f));
        i2crtc_pkg::RegYear:    return 8'((((yr % 100) / 10) << 4) + yr % 10);
        i2crtc_pkg::RegControl: return {3'b000, control};
        i2crtc_pkg::RegStatus:  return status;
        i2crtc_pkg::RegAging:   return aging;
        i2crtc_pkg::RegTempHi:  return i2crtc_pkg::TempHiValue;
        i2crtc_pkg::RegTempLo:  return i2crtc_pkg::TempLoValue;
        default: begin
          if (r >= i2crtc_pkg::RegA1Sec && r <= i2crtc_pkg::RegA2Day)
            return alarm_q[r - i2crtc_pkg::RegA1Sec];
          return 8'h00;
        end
      endcase
    endfunction

    function void note_beat(i2crtc_pkg::in_item_t it);
      i2crtc_pkg::out_item_t res;
      logic [4:0]            p;
      res.read_data = 8'h00;
      p = ptr;
      case (it.operation)
        i2crtc_pkg::OpStart: begin
          prev_sec = snap_t.sec;
          prev_min = snap_t.min;
          snap_t   = it.now;
          pending  = 1'b1;
          check_alarms();
        end
        i2crtc_pkg::OpWrite: begin
          if (pending) begin
            ptr     = 5'(it.data_byte % i2crtc_pkg::RegisterCount);
            pending = 1'b0;
          end else begin
            store_byte(p, it.data_byte);
            ptr = (p == i2crtc_pkg::RegLast) ? 5'd0 : p + 5'd1;
          end
        end
        i2crtc_pkg::OpRead: begin
          res.read_data = fetch_byte(p);
          ptr = (p == i2crtc_pkg::RegLast) ? 5'd0 : p + 5'd1;
        end
        default: ;
      endcase
      res.alarm1_flag = status[0];
      res.alarm2_flag = status[1];
      due_responses.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_beat(i2crtc_pkg::out_item_t got);
      i2crtc_pkg::out_item_t want;
      if (due_responses.size() == 0) begin
        report("result beat with nothing outstanding");
      end else begin
        want = due_responses.pop_front();
        if (got.read_data !== want.read_data)
          report($sformatf("read_data %02h, want %02h", got.read_data, want.read_data));
        if (got.alarm1_flag !== want.alarm1_flag)
          report($sformatf("alarm1_flag %b, want %b", got.alarm1_flag, want.alarm1_flag));
        if (got.alarm2_flag !== want.alarm2_flag)
          report($sformatf("alarm2_flag %b, want %b", got.alarm2_flag, want.alarm2_flag));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic hold_rx = 1'b0;
  int   send_idle = 0;
  int   stall_pct = 0;
  int   beats_sent = 0;
  int   quiet = 0;
  rtc_scoreboard sb = new();

  i2crtc_in_if  in_ch ();
  i2crtc_out_if out_ch ();

  i2c_rtc_register_model i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch.sink),
    .out_bus (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly near zero so the alarm registers have a chance to match
  function automatic i2crtc_pkg::time_t sample_clock();
    i2crtc_pkg::time_t t;
    if ($urandom_range(0, 9) < 6) begin
      t.sec   = 6'($urandom_range(0, 1));
      t.min   = 6'($urandom_range(0, 1));
      t.hour  = ($urandom_range(0, 1) ? 5'd12 : 5'd0) + 5'($urandom_range(0, 1));
      t.wday  = 3'($urandom_range(0, 1));
      t.mday  = 5'($urandom_range(1, 2));
      t.month = 4'($urandom_range(0, 11));
      t.year  = 8'($urandom_range(0, 199));
    end else begin
      t = i2crtc_pkg::time_t'($urandom ^ ({$urandom, 32'h0} >> 5));
      t.year = 8'($urandom);
    end
    return t;
  endfunction

  task automatic send_beat(input i2crtc_pkg::op_t op, input logic [7:0] d,
                           input i2crtc_pkg::time_t t);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.data_byte    <= d;
    in_ch.now_second   <= t.sec;
    in_ch.now_minute   <= t.min;
    in_ch.now_hour     <= t.hour;
    in_ch.now_weekday  <= t.wday;
    in_ch.now_monthday <= t.mday;
    in_ch.now_month    <= t.month;
    in_ch.now_year     <= t.year;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic run_phase(input int s_idle, input int r_stall, input int beats);
    int         target;
    int         kind;
    int         n;
    logic [4:0] p;
    logic [7:0] b;
    send_idle = s_idle;
    stall_pct = r_stall;
    target    = beats_sent + beats;
    while (beats_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind >= 95) begin
        // loose bus noise
        n = $urandom_range(1, 6);
        repeat (n) send_beat(i2crtc_pkg::op_t'($urandom_range(0, 3)), 8'($urandom),
                             sample_clock());
      end else begin
        send_beat(i2crtc_pkg::OpStart, 8'($urandom), sample_clock());
        if (kind < 25) begin
          p = i2crtc_pkg::RegA1Sec + 5'($urandom_range(0, i2crtc_pkg::AlarmCount - 1));
        end else if (kind < 40) begin
          p = i2crtc_pkg::RegStatus;
        end else if (kind < 50) begin
          case ($urandom_range(0, 2))
            0:       p = i2crtc_pkg::RegHour;
            1:       p = i2crtc_pkg::RegControl;
            default: p = i2crtc_pkg::RegAging;
          endcase
        end else begin
          p = 5'($urandom_range(0, i2crtc_pkg::RegisterCount - 1));
        end
        b = {3'b000, p};
        if ($urandom_range(0, 9) == 0) b = 8'($urandom);
        p = 5'(b % i2crtc_pkg::RegisterCount);
        send_beat(i2crtc_pkg::OpWrite, b, sample_clock());
        n = (kind < 25) ? $urandom_range(1, 7) : (kind < 50) ? 1 : $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          if (kind >= 50 && kind < 85) begin
            send_beat(i2crtc_pkg::OpRead, 8'($urandom), sample_clock());
          end else begin
            b = 8'($urandom);
            if (p >= i2crtc_pkg::RegA1Sec && p <= i2crtc_pkg::RegA2Day &&
                $urandom_range(0, 9) != 0) begin
              case (p - i2crtc_pkg::RegA1Sec)
                0, 1, 4: b = 8'($urandom_range(0, 1));
                2, 5: begin
                  case ($urandom_range(0, 7))
                    0:       b = 8'h00;
                    1:       b = 8'h01;
                    2:       b = 8'h12;
                    3:       b = 8'h13;
                    4:       b = 8'h52;
                    5:       b = 8'h41;
                    6:       b = 8'h72;
                    default: b = 8'h61;
                  endcase
                end
                default: b = {1'b0, 1'($urandom), 6'($urandom_range(1, 2))};
              endcase
              if ($urandom_range(0, 3) == 0) b[7] = 1'b1;
            end
            send_beat(i2crtc_pkg::OpWrite, b, sample_clock());
          end
          p = (p == i2crtc_pkg::RegLast) ? 5'd0 : p + 5'd1;
        end
        if ($urandom_range(0, 9) != 0) begin
          send_beat(i2crtc_pkg::OpStop, 8'($urandom), sample_clock());
        end
      end
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // scoreboard taps and no-progress watchdog
  always @(posedge clk) begin
    i2crtc_pkg::in_item_t  seen;
    i2crtc_pkg::out_item_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.operation  = in_ch.operation;
        seen.data_byte  = in_ch.data_byte;
        seen.now.sec    = in_ch.now_second;
        seen.now.min    = in_ch.now_minute;
        seen.now.hour   = in_ch.now_hour;
        seen.now.wday   = in_ch.now_weekday;
        seen.now.mday   = in_ch.now_monthday;
        seen.now.month  = in_ch.now_month;
        seen.now.year   = in_ch.now_year;
        sb.note_beat(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.read_data   = out_ch.read_data;
        got.alarm1_flag = out_ch.alarm1_flag;
        got.alarm2_flag = out_ch.alarm2_flag;
        sb.check_beat(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    i2crtc_pkg::time_t t;
    logic [7:0]        alarm_init [7];
    logic [7:0]        upper_init [8];
    alarm_init = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00};
    // control, status, aging, both temperatures, then wrap to sec, min, hour
    upper_init = '{8'hff, 8'h00, 8'hff, 8'haa, 8'h55, 8'hff, 8'hff, 8'h40};
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= i2crtc_pkg::OpStop;
    in_ch.data_byte    <= '0;
    in_ch.now_second   <= '0;
    in_ch.now_minute   <= '0;
    in_ch.now_hour     <= '0;
    in_ch.now_weekday  <= '0;
    in_ch.now_monthday <= '0;
    in_ch.now_month    <= '0;
    in_ch.now_year     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every time field at its widest, read before the pointer byte, then all time regs
    t = '1;
    send_beat(i2crtc_pkg::OpStart, 8'h00, t);
    send_beat(i2crtc_pkg::OpRead, 8'hff, t);
    send_beat(i2crtc_pkg::OpWrite, 8'd19, t);
    repeat (7) send_beat(i2crtc_pkg::OpRead, 8'h00, t);
    foreach (alarm_init[i]) send_beat(i2crtc_pkg::OpWrite, alarm_init[i], t);
    foreach (upper_init[i]) send_beat(i2crtc_pkg::OpWrite, upper_init[i], t);
    // noon in 12-hour mode, century bit set, second and minute both moved
    t       = '0;
    t.hour  = 5'd12;
    t.mday  = 5'd1;
    t.year  = 8'd100;
    send_beat(i2crtc_pkg::OpStart, 8'hff, t);
    send_beat(i2crtc_pkg::OpWrite, 8'd21, t);
    send_beat(i2crtc_pkg::OpRead, 8'h00, t);
    send_beat(i2crtc_pkg::OpStop, 8'h00, t);

    fork
      begin
        hold_rx <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_rx <= 1'b0;
      end
      run_phase(0, 0, 250);
    join
    run_phase(74, 0, 250);
    run_phase(0, 74, 250);
    run_phase(24, 24, 250);
    in_ch.valid <= 1'b0;

    while (sb.due_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### i2c_rtc_register_model.f
+incdir+design
design/i2crtc_pkg.sv
design/i2crtc_if.sv
design/i2c_rtc_register_model.sv
tb/tb.sv
